### rtl/mmf_pkg.sv
`default_nettype none

package mmf_pkg;

  localparam logic [7:0] ST_REALTIME = 8'hF8;
  localparam logic [7:0] ST_SYSEX = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END = 8'hF7;
  localparam logic [7:0] ST_QFRAME = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_TUNE_REQ = 8'hF6;
  localparam logic [7:0] ST_PROG_CHG = 8'hC0;
  localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
  localparam logic [7:0] ST_STATUS_BIT = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROC,
    S_EMIT,
    S_QF_HEAD,
    S_QF_TAIL,
    S_READ,
    S_SEND
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_DIRECT,
    ACT_QF,
    ACT_DRAIN
  } act_t;

  typedef enum logic [1:0] {
    OSRC_BYTE,
    OSRC_QF_HEAD,
    OSRC_STORE
  } osrc_t;

  typedef struct packed {
    logic  capture;
    logic  process;
    logic  read;
    logic  advance;
    logic  load;
    osrc_t osrc;
  } ctrl_cmd_t;

  typedef struct packed {
    act_t act;
    logic slot_free;
    logic drain_last;
  } dp_status_t;

  // Total message length including the status byte; zero marks SysEx, realtime or
  // an undefined status.
  function automatic logic [1:0] len_of_status(input logic [7:0] s);
    logic [1:0] len;
    if (s >= ST_SYSEX) begin
      if (s == ST_QFRAME || s == ST_SONG_SEL) begin
        len = 2'd2;
      end else if (s == ST_SONG_POS) begin
        len = 2'd3;
      end else if (s == ST_TUNE_REQ) begin
        len = 2'd1;
      end else begin
        len = 2'd0;
      end
    end else if ((s & 8'hF0) == ST_PROG_CHG || (s & 8'hF0) == ST_CHAN_PRESS) begin
      len = 2'd2;
    end else begin
      len = 2'd3;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/mmf_ctrl.sv
`default_nettype none

module mmf_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  mmf_pkg::dp_status_t    status,
  output mmf_pkg::ctrl_cmd_t     cmd
);
  import mmf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_PROC;
      end
      S_PROC: begin
        unique case (status.act)
          ACT_NONE:   state_next = S_IDLE;
          ACT_DIRECT: state_next = S_EMIT;
          ACT_QF:     state_next = S_QF_HEAD;
          ACT_DRAIN:  state_next = S_READ;
          default:    state_next = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (status.slot_free) state_next = S_IDLE;
      end
      S_QF_HEAD: begin
        if (status.slot_free) state_next = S_QF_TAIL;
      end
      S_QF_TAIL: begin
        if (status.slot_free) state_next = S_IDLE;
      end
      S_READ: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (status.slot_free) state_next = status.drain_last ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.osrc    = OSRC_BYTE;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_PROC: begin
        cmd.process = 1'b1;
      end
      S_EMIT, S_QF_TAIL: begin
        cmd.load = status.slot_free;
        cmd.osrc = OSRC_BYTE;
      end
      S_QF_HEAD: begin
        cmd.load = status.slot_free;
        cmd.osrc = OSRC_QF_HEAD;
      end
      S_READ: begin
        cmd.read = 1'b1;
      end
      S_SEND: begin
        cmd.load    = status.slot_free;
        cmd.osrc    = OSRC_STORE;
        cmd.advance = status.slot_free && !status.drain_last;
      end
      default: begin
        cmd.process = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/mmf_datapath.sv
`default_nettype none

module mmf_datapath #(
  parameter int SYSEX_HOLD = 63
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire  [7:0]             in_byte,
  input  mmf_pkg::ctrl_cmd_t     cmd,
  output mmf_pkg::dp_status_t    status,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [7:0]             out_byte,
  output logic                   last_of_message
);
  import mmf_pkg::*;

  localparam int DEPTH = SYSEX_HOLD + 1;
  localparam int CNT_W = $clog2(SYSEX_HOLD + 2);
  localparam int IDX_W = $clog2(DEPTH);

  // Index zero of a message is kept in msg_status; the store holds the rest.
  logic [7:0]       mem [DEPTH];
  logic [7:0]       mem_q;

  logic [7:0]       cur_byte;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       exp_len;
  logic [7:0]       run_status;
  logic [7:0]       msg_status;
  logic             sysex_open;
  logic             qf_pending;
  logic [CNT_W-1:0] drain_len;
  logic [CNT_W-1:0] rd_idx;

  logic [CNT_W-1:0] cnt_next;
  logic [1:0]       exp_len_next;
  logic [7:0]       run_status_next;
  logic [7:0]       msg_status_next;
  logic             sysex_open_next;
  logic             qf_pending_next;
  logic [CNT_W-1:0] drain_len_next;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       wr_data;
  act_t             act;

  always_comb begin
    logic             incomplete;
    logic             qf_open;
    logic [1:0]       blen;
    logic [CNT_W-1:0] base_cnt;
    logic [CNT_W-1:0] new_cnt;
    logic [1:0]       elen;
    cnt_next        = cnt;
    exp_len_next    = exp_len;
    run_status_next = run_status;
    msg_status_next = msg_status;
    sysex_open_next = sysex_open;
    qf_pending_next = qf_pending;
    drain_len_next  = drain_len;
    wr_en           = 1'b0;
    wr_idx          = cnt[IDX_W-1:0];
    wr_data         = cur_byte;
    act             = ACT_NONE;
    incomplete = sysex_open || (exp_len != 2'd0 && cnt < CNT_W'(exp_len));
    qf_open    = !sysex_open && cnt != '0 && msg_status == ST_QFRAME;
    blen       = len_of_status(cur_byte);
    base_cnt   = (cnt == '0) ? CNT_W'(1) : cnt;
    new_cnt    = base_cnt + CNT_W'(1);
    elen       = (cnt == '0) ? len_of_status(run_status) : exp_len;

    if (cur_byte[7]) begin
      if (cur_byte >= ST_REALTIME) begin
        act = ACT_DIRECT;
      end else if (cur_byte == ST_QFRAME && incomplete && !qf_open) begin
        // A quarter frame nests inside the open message, which resumes after it.
        qf_pending_next = 1'b1;
      end else begin
        qf_pending_next = 1'b0;
        if (cur_byte == ST_SYSEX) begin
          cnt_next        = CNT_W'(1);
          msg_status_next = ST_SYSEX;
          sysex_open_next = 1'b1;
          exp_len_next    = 2'd0;
          run_status_next = 8'h00;
        end else if (cur_byte == ST_SYSEX_END) begin
          if (sysex_open) begin
            wr_en           = 1'b1;
            drain_len_next  = cnt + CNT_W'(1);
            cnt_next        = '0;
            exp_len_next    = 2'd0;
            sysex_open_next = 1'b0;
            act             = ACT_DRAIN;
          end
        end else begin
          sysex_open_next = 1'b0;
          if (blen == 2'd0) begin
            cnt_next     = '0;
            exp_len_next = 2'd0;
          end else begin
            msg_status_next = cur_byte;
            run_status_next = (cur_byte < ST_SYSEX) ? cur_byte : 8'h00;
            if (blen == 2'd1) begin
              drain_len_next = CNT_W'(1);
              cnt_next       = '0;
              exp_len_next   = 2'd0;
              act            = ACT_DRAIN;
            end else begin
              cnt_next     = CNT_W'(1);
              exp_len_next = blen;
            end
          end
        end
      end
    end else if (qf_pending) begin
      qf_pending_next = 1'b0;
      act             = ACT_QF;
    end else if (sysex_open) begin
      if (cnt >= CNT_W'(SYSEX_HOLD)) begin
        // Overflow drops everything, running status included.
        cnt_next        = '0;
        exp_len_next    = 2'd0;
        run_status_next = 8'h00;
        sysex_open_next = 1'b0;
      end else begin
        wr_en    = 1'b1;
        cnt_next = cnt + CNT_W'(1);
      end
    end else if (cnt != '0 || run_status != 8'h00) begin
      if (cnt == '0) msg_status_next = run_status;
      wr_en  = 1'b1;
      wr_idx = base_cnt[IDX_W-1:0];
      if (elen != 2'd0 && new_cnt >= CNT_W'(elen)) begin
        drain_len_next = new_cnt;
        cnt_next       = '0;
        exp_len_next   = 2'd0;
        act            = ACT_DRAIN;
      end else begin
        cnt_next     = new_cnt;
        exp_len_next = elen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.process && wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.read) begin
      mem_q <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      exp_len    <= 2'd0;
      run_status <= 8'h00;
      sysex_open <= 1'b0;
      qf_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.process) begin
        cnt        <= cnt_next;
        exp_len    <= exp_len_next;
        run_status <= run_status_next;
        sysex_open <= sysex_open_next;
        qf_pending <= qf_pending_next;
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_byte <= in_byte;
    end
    if (cmd.process) begin
      msg_status <= msg_status_next;
      drain_len  <= drain_len_next;
      rd_idx     <= '0;
    end else if (cmd.advance) begin
      rd_idx <= rd_idx + CNT_W'(1);
    end
    if (cmd.load) begin
      unique case (cmd.osrc)
        OSRC_BYTE: begin
          out_byte        <= cur_byte;
          last_of_message <= 1'b1;
        end
        OSRC_QF_HEAD: begin
          out_byte        <= ST_QFRAME;
          last_of_message <= 1'b0;
        end
        OSRC_STORE: begin
          out_byte        <= (rd_idx == '0) ? msg_status : mem_q;
          last_of_message <= status.drain_last;
        end
        default: begin
          out_byte        <= cur_byte;
          last_of_message <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    status.act        = act;
    status.slot_free  = !out_valid || out_ready;
    status.drain_last = (rd_idx == drain_len - CNT_W'(1));
  end

endmodule

`default_nettype wire

### rtl/midi_message_framer_unit.sv
`default_nettype none

// MIDI message framer: takes one raw MIDI byte per request and delivers
// complete messages byte by byte, last_of_message high on the final byte.
// Realtime bytes pass straight through, channel and system common messages
// are framed to their lengths with running status for channel messages, and
// SysEx is held until F7 and then sent whole. A byte that completes nothing
// passes through capture, then decode and state update. A realtime byte is
// loaded in the EMIT state and a nested quarter frame in QF_HEAD and QF_TAIL,
// and a completed message passes READ then SEND per byte, since each byte
// is read from the single port message store with a registered read before
// it enters the output register. The store has SYSEX_HOLD + 1 entries and
// needs no clearing after reset. The output register lets a new byte be
// accepted while a result still waits to be taken.
module midi_message_framer_unit #(
  parameter int SYSEX_HOLD = 63
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_message
);
  import mmf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mmf_datapath #(
    .SYSEX_HOLD (SYSEX_HOLD)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .in_byte         (in_byte),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .last_of_message (last_of_message)
  );

endmodule

`default_nettype wire

### rtl/mmf_checker.sv
`default_nettype none

module mmf_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [7:0]  out_byte,
  input wire        last_of_message
);
  import mmf_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_message))
    else $error("stalled output changed");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  // Every message starts with a status byte.
  a_starts_with_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_of_message |=> !out_valid || out_byte[7])
    else $error("message does not start with a status byte");

  // Realtime bytes are always one-byte messages.
  a_realtime_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_byte >= ST_REALTIME |-> last_of_message)
    else $error("realtime byte not flagged as last");

endmodule

bind midi_message_framer_unit mmf_checker u_mmf_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .last_of_message (last_of_message)
);

`default_nettype wire
